// ----- hdl/chscan_pkg.sv -----
// chscan_pkg: shared types, constants and the channel frequency table
// for the channel scan controller
// no dependencies
`default_nettype none

package chscan_pkg;

  localparam int unsigned CHANNEL_COUNT = 10;
  localparam int unsigned CHAN_W        = 4;
  localparam int unsigned FREQ_W        = 24;
  localparam int unsigned TIMER_W       = 8;
  localparam int unsigned CONFIRM_W     = 3;
  localparam int unsigned MODE_W        = 2;
  localparam int unsigned CFG_IDX_W     = 2;
  localparam int unsigned CFG_DATA_W    = 8;
  localparam int unsigned IN_DATA_W     = 8;
  localparam int unsigned OUT_DATA_W    = 40;

  localparam logic [CHAN_W-1:0] LAST_CHAN = CHAN_W'(CHANNEL_COUNT - 1);

  localparam logic [TIMER_W-1:0] STEP_DWELL      = 8'd2;
  localparam logic [TIMER_W-1:0] START_DWELL     = 8'd4;
  localparam logic [TIMER_W-1:0] CARRIER_REFRESH = 8'd50;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_POLL     = 3'd1,
    REQ_KEY_UP   = 3'd2,
    REQ_KEY_DOWN = 3'd3,
    REQ_KEY_SCAN = 3'd4
  } req_t;

  typedef enum logic [2:0] {
    PH_IDLE        = 3'd0,
    PH_SCAN        = 3'd1,
    PH_WAIT_TIME   = 3'd2,
    PH_WAIT_LOST   = 3'd3,
    PH_WAIT_RECALL = 3'd4,
    PH_STOP        = 3'd5
  } phase_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_TIME_HOLD    = 2'd0,
    MODE_CARRIER_HOLD = 2'd1,
    MODE_STOP_ON_FIND = 2'd2,
    MODE_UNUSED       = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN_MODE     = 2'd0,
    CFG_HOLD_TIME     = 2'd1,
    CFG_FIND_TIME     = 2'd2,
    CFG_CONFIRM_LIMIT = 2'd3
  } cfg_idx_t;

  // next channel with wrap-around in either direction
  function automatic logic [CHAN_W-1:0] step_chan(input logic [CHAN_W-1:0] chan,
                                                  input logic up);
    logic [CHAN_W-1:0] res;
    if (up) begin
      res = (chan >= LAST_CHAN) ? '0 : chan + 1'b1;
    end else begin
      res = (chan == '0) ? LAST_CHAN : chan - 1'b1;
    end
    return res;
  endfunction

  // tuned frequency in 10 Hz units
  function automatic logic [FREQ_W-1:0] chan_freq(input logic [CHAN_W-1:0] chan);
    logic [FREQ_W-1:0] f;
    case (chan)
      4'd0:    f = 24'd16255000;
      4'd1:    f = 24'd16240000;
      4'd2:    f = 24'd16247500;
      4'd3:    f = 24'd16242500;
      4'd4:    f = 24'd16245000;
      4'd5:    f = 24'd16250000;
      4'd6:    f = 24'd16252500;
      4'd7:    f = 24'd16165000;
      4'd8:    f = 24'd16177500;
      4'd9:    f = 24'd16327500;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/channel_scan_controller.sv -----
// channel_scan_controller: scan state, channel stepping and result register
// depends on chscan_pkg
`default_nettype none

// One request per clock: a request accepted at one edge updates the scan
// state at that edge and its result is loaded into the output register at
// that same edge. in_tready stays high while the output register is empty
// or being drained, so back-to-back requests run at full rate; it drops only
// when a result waits and out_tready is low. The state update is a single
// pass of short logic from the request and the state registers.
module channel_scan_controller
  import chscan_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [2:0] req_type, [3] squelch_open, [7:4] zero
  input  wire logic [IN_DATA_W-1:0]  in_tdata,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [3:0] channel, [27:4] frequency, [30:28] scan_state,
  // [31] channel_changed, [32] key_beep, [39:33] zero
  output logic [OUT_DATA_W-1:0]      out_tdata
);

  mode_t                scan_mode_r;
  logic [TIMER_W-1:0]   hold_time_r;
  logic [TIMER_W-1:0]   find_time_r;
  logic [CONFIRM_W-1:0] confirm_limit_r;

  logic [CHAN_W-1:0]    chan_r, chan_nxt;
  phase_t               phase_r, phase_nxt;
  logic                 up_r, up_nxt;
  logic [TIMER_W-1:0]   timer_r, timer_nxt;
  logic [CONFIRM_W-1:0] cnt_r, cnt_nxt;
  logic                 changed_nxt, beep_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [FREQ_W-1:0]    freq_r, freq_nxt;
  logic                 changed_r, beep_r;

  logic                 accept;
  req_t                 req;
  logic                 sq;

  assign req       = req_t'(in_tdata[2:0]);
  assign sq        = in_tdata[3];
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_mode_r     <= MODE_TIME_HOLD;
      hold_time_r     <= 8'd20;
      find_time_r     <= 8'd20;
      confirm_limit_r <= 3'd3;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SCAN_MODE:     scan_mode_r     <= mode_t'(cfg_data[MODE_W-1:0]);
        CFG_HOLD_TIME:     hold_time_r     <= cfg_data[TIMER_W-1:0];
        CFG_FIND_TIME:     find_time_r     <= cfg_data[TIMER_W-1:0];
        CFG_CONFIRM_LIMIT: confirm_limit_r <= cfg_data[CONFIRM_W-1:0];
        default: ;
      endcase
    end
  end

  // next scan state
  always_comb begin
    chan_nxt    = chan_r;
    phase_nxt   = phase_r;
    up_nxt      = up_r;
    timer_nxt   = timer_r;
    cnt_nxt     = cnt_r;
    changed_nxt = 1'b0;
    beep_nxt    = 1'b0;
    unique case (req) inside
      REQ_TICK: begin
        if (timer_r != '0) timer_nxt = timer_r - 1'b1;
      end
      REQ_POLL: begin
        case (phase_r)
          PH_SCAN: begin
            if (sq) begin
              if (cnt_r < confirm_limit_r) begin
                cnt_nxt = cnt_r + 1'b1;
              end else begin
                case (scan_mode_r)
                  MODE_TIME_HOLD: begin
                    phase_nxt = PH_WAIT_TIME;
                    timer_nxt = hold_time_r;
                  end
                  MODE_CARRIER_HOLD: begin
                    phase_nxt = PH_WAIT_LOST;
                    timer_nxt = hold_time_r;
                  end
                  MODE_STOP_ON_FIND: begin
                    phase_nxt = PH_STOP;
                    timer_nxt = find_time_r;
                  end
                  default: ;
                endcase
              end
            end else begin
              cnt_nxt = '0;
              if (timer_r == '0) begin
                chan_nxt    = step_chan(chan_r, up_r);
                timer_nxt   = STEP_DWELL;
                changed_nxt = 1'b1;
              end
            end
          end
          PH_WAIT_TIME: begin
            cnt_nxt = '0;
            if (!(scan_mode_r == MODE_CARRIER_HOLD && sq) && timer_r == '0) begin
              chan_nxt    = step_chan(chan_r, up_r);
              phase_nxt   = PH_SCAN;
              timer_nxt   = STEP_DWELL;
              changed_nxt = 1'b1;
            end else if (scan_mode_r == MODE_CARRIER_HOLD && sq) begin
              timer_nxt = CARRIER_REFRESH;
            end
          end
          PH_WAIT_LOST: begin
            if (sq) begin
              timer_nxt = hold_time_r;
            end else if (timer_r == '0) begin
              phase_nxt = PH_WAIT_RECALL;
            end
          end
          PH_WAIT_RECALL: begin
            cnt_nxt = '0;
            if (timer_r == '0) begin
              chan_nxt    = step_chan(chan_r, up_r);
              phase_nxt   = PH_SCAN;
              timer_nxt   = STEP_DWELL;
              changed_nxt = 1'b1;
            end
          end
          PH_STOP: begin
            phase_nxt = PH_IDLE;
            timer_nxt = '0;
            cnt_nxt   = '0;
          end
          default: ;
        endcase
      end
      REQ_KEY_UP, REQ_KEY_DOWN: begin
        beep_nxt    = 1'b1;
        changed_nxt = 1'b1;
        chan_nxt    = step_chan(chan_r, req == REQ_KEY_UP);
        if (phase_r != PH_IDLE) begin
          // key resumes scanning in the chosen direction
          up_nxt    = (req == REQ_KEY_UP);
          phase_nxt = PH_SCAN;
          timer_nxt = STEP_DWELL;
        end
      end
      REQ_KEY_SCAN: begin
        if (phase_r == PH_IDLE) begin
          phase_nxt = PH_SCAN;
          timer_nxt = START_DWELL;
          up_nxt    = 1'b1;
        end else begin
          phase_nxt = PH_IDLE;
          timer_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  // result register handshake
  always_comb begin
    freq_nxt = chan_freq(chan_nxt);
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      phase_r     <= PH_IDLE;
      up_r        <= 1'b1;
      timer_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        chan_r  <= chan_nxt;
        phase_r <= phase_nxt;
        up_r    <= up_nxt;
        timer_r <= timer_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      freq_r    <= freq_nxt;
      changed_r <= changed_nxt;
      beep_r    <= beep_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, beep_r, changed_r, phase_r, freq_r, chan_r};

endmodule

`default_nettype wire
